// ===== rtl/cla_pkg.sv =====
package cla_pkg;

    localparam int LINE_SIZE = 64;
    localparam int ADDR_W    = $clog2(LINE_SIZE);
    localparam int LEN_W     = $clog2(LINE_SIZE + 1);

    localparam logic [7:0] CH_BS        = 8'd8;
    localparam logic [7:0] CH_LF        = 8'd10;
    localparam logic [7:0] CH_CR        = 8'd13;
    localparam logic [7:0] CH_ESC       = 8'd27;
    localparam logic [7:0] CH_BRACKET   = 8'd91;
    localparam logic [7:0] CH_UP        = 8'd65;
    localparam logic [7:0] CH_PRINT_MIN = 8'd32;

    localparam logic KIND_LINE    = 1'b0;
    localparam logic KIND_OVERRUN = 1'b1;

    typedef enum logic [1:0] {
        ESC_NONE    = 2'd0,
        ESC_SEEN    = 2'd1,
        ESC_BRACKET = 2'd2
    } t_esc;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMIT_RD,
        S_EMIT_WR,
        S_COPY_RD,
        S_COPY_WR,
        S_OVERRUN
    } t_state;

endpackage

// ===== rtl/cla_ram.sv =====
module cla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/command_line_assembler_core.sv =====
// command line assembler: builds a command line from host bytes, one request
// a byte on the s_axis side, and sends each finished line out on the m_axis
// side as a run of bytes closed by CR, tlast on the CR
// tuser 0 marks a line byte, tuser 1 an overrun (tdata 0, tlast 1): the line
// filled up and was thrown away
// a printable byte, backspace or escape byte is handled in the idle state
// a byte that fills the line leads to the overrun state, which loads the overrun result
// on a line end each stored character is read from the line memory, then
// written to the history memory and loaded into the output register, and a
// closing CR follows the last one
// recall (ESC [ A) copies each history character from the history memory
// back to the line memory through its read port
// s_axis tready is high only in the idle state; a result sits in a single
// output register, so the next byte is taken while it waits for the sink
// when the sink stalls, a run simply pauses on the full output register
// reset clears lengths, escape state and the output valid flag; both memories
// are left as they are, as no entry is read before it is written
module command_line_assembler_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tuser,   // [0] kind
    output logic       o_m_axis_tlast
);

    localparam int AW = cla_pkg::ADDR_W;
    localparam int LW = cla_pkg::LEN_W;

    cla_pkg::t_state r_state, n_state;
    cla_pkg::t_esc   r_esc, n_esc;
    logic [LW-1:0]   r_line_len, n_line_len;
    logic [LW-1:0]   r_hist_len, n_hist_len;
    logic [LW-1:0]   r_count, n_count;     // entries to walk in a copy
    logic [LW-1:0]   r_idx, n_idx;         // walk position
    logic            r_after_end, n_after_end;

    // output register
    logic            r_out_valid, n_out_valid;
    logic [7:0]      r_out_data, n_out_data;
    logic            r_out_user, n_out_user;
    logic            r_out_last, n_out_last;

    // memory ports
    logic            line_we, line_re, hist_we, hist_re;
    logic [AW-1:0]   line_waddr, hist_waddr;
    logic [7:0]      line_wdata, line_rdata, hist_rdata;

    logic            s_accept;
    logic            out_free;
    logic [7:0]      b;
    logic            is_eol;

    cla_ram #(.WIDTH(8), .DEPTH(cla_pkg::LINE_SIZE)) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (line_waddr),
        .i_wdata (line_wdata),
        .i_re    (line_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (line_rdata)
    );

    cla_ram #(.WIDTH(8), .DEPTH(cla_pkg::LINE_SIZE)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (line_rdata),
        .i_re    (hist_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (hist_rdata)
    );

    assign o_s_axis_tready = (r_state == cla_pkg::S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign b               = i_s_axis_tdata;
    assign is_eol          = (b == cla_pkg::CH_CR) || (b == cla_pkg::CH_LF);

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;
    assign o_m_axis_tlast  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cla_pkg::S_IDLE;
            r_esc       <= cla_pkg::ESC_NONE;
            r_line_len  <= '0;
            r_hist_len  <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_after_end <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_esc       <= n_esc;
            r_line_len  <= n_line_len;
            r_hist_len  <= n_hist_len;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_after_end <= n_after_end;
            r_out_valid <= n_out_valid;
        end
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_esc       = r_esc;
        n_line_len  = r_line_len;
        n_hist_len  = r_hist_len;
        n_count     = r_count;
        n_idx       = r_idx;
        n_after_end = r_after_end;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        n_out_last  = r_out_last;

        line_we    = 1'b0;
        line_re    = 1'b0;
        line_waddr = r_line_len[AW-1:0];
        line_wdata = b;
        hist_we    = 1'b0;
        hist_re    = 1'b0;
        hist_waddr = r_idx[AW-1:0];

        unique case (r_state)
            cla_pkg::S_IDLE: begin
                if (s_accept) begin
                    if (!r_after_end && is_eol) begin
                        // line end: escape state is kept
                        n_after_end = 1'b1;
                        n_hist_len  = r_line_len;
                        n_count     = r_line_len;
                        n_idx       = '0;
                        n_line_len  = '0;
                        n_state     = cla_pkg::S_EMIT_RD;
                    end else if (b == cla_pkg::CH_ESC && r_esc == cla_pkg::ESC_NONE) begin
                        n_esc = cla_pkg::ESC_SEEN;
                    end else if (r_esc == cla_pkg::ESC_SEEN && b == cla_pkg::CH_BRACKET) begin
                        n_esc = cla_pkg::ESC_BRACKET;
                    end else if (r_esc == cla_pkg::ESC_BRACKET && b == cla_pkg::CH_UP) begin
                        // recall: history is copied back into the line
                        n_esc      = cla_pkg::ESC_NONE;
                        n_count    = r_hist_len;
                        n_line_len = r_hist_len;
                        n_idx      = '0;
                        n_state    = cla_pkg::S_COPY_RD;
                    end else if (b == cla_pkg::CH_BS && r_line_len != '0) begin
                        n_line_len = r_line_len - LW'(1);
                    end else if (!is_eol && b >= cla_pkg::CH_PRINT_MIN) begin
                        n_esc       = cla_pkg::ESC_NONE;
                        n_after_end = 1'b0;
                        line_we     = 1'b1;
                        if (r_line_len == LW'(cla_pkg::LINE_SIZE - 1)) begin
                            n_line_len = '0;
                            n_state    = cla_pkg::S_OVERRUN;
                        end else begin
                            n_line_len = r_line_len + LW'(1);
                        end
                    end
                end
            end
            cla_pkg::S_EMIT_RD: begin
                if (r_idx < r_count) begin
                    line_re = 1'b1;
                    n_state = cla_pkg::S_EMIT_WR;
                end else if (out_free) begin
                    // closing CR of the run
                    n_out_valid = 1'b1;
                    n_out_data  = cla_pkg::CH_CR;
                    n_out_user  = cla_pkg::KIND_LINE;
                    n_out_last  = 1'b1;
                    n_state     = cla_pkg::S_IDLE;
                end
            end
            cla_pkg::S_EMIT_WR: begin
                if (out_free) begin
                    hist_we     = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_data  = line_rdata;
                    n_out_user  = cla_pkg::KIND_LINE;
                    n_out_last  = 1'b0;
                    n_idx       = r_idx + LW'(1);
                    n_state     = cla_pkg::S_EMIT_RD;
                end
            end
            cla_pkg::S_COPY_RD: begin
                if (r_idx < r_count) begin
                    hist_re = 1'b1;
                    n_state = cla_pkg::S_COPY_WR;
                end else begin
                    n_state = cla_pkg::S_IDLE;
                end
            end
            cla_pkg::S_COPY_WR: begin
                line_we    = 1'b1;
                line_waddr = r_idx[AW-1:0];
                line_wdata = hist_rdata;
                n_idx      = r_idx + LW'(1);
                n_state    = cla_pkg::S_COPY_RD;
            end
            cla_pkg::S_OVERRUN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = 8'd0;
                    n_out_user  = cla_pkg::KIND_OVERRUN;
                    n_out_last  = 1'b1;
                    n_state     = cla_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cla_pkg::S_IDLE;
            end
        endcase
    end

endmodule
